// ===== design/sbrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrg_pkg
// Shared types and constants of the square block rotate grid.
// ----------------------------------------------------------------------------
package sbrg_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int CELL_W       = 13;
    localparam int SIDE_W       = 7;
    localparam int POS_W        = 7;
    localparam int RAD_W        = 5;
    localparam logic [SIDE_W-1:0] GRID_SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_NUMBER = 2'd0,
        OP_ROTATE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_NUMBER,
        S_COPY,
        S_COPY_END,
        S_BACK,
        S_BACK_END,
        S_RD_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [POS_W-1:0] pos_row;
        logic [POS_W-1:0] pos_col;
        logic [RAD_W-1:0] radius;
        logic             direction;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic done;
        logic status;
    } t_seq_stat;

endpackage

// ===== design/sbrg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbrg_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sbrg_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrg_seq
// Command sequencer: reset fill, numbering, two-pass rotation and cell read.
// ----------------------------------------------------------------------------
module sbrg_seq #(
    parameter int MAX_SIDE = sbrg_pkg::MAX_SIDE_DEF,
    parameter int AW       = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbrg_pkg::t_cmd                i_cmd,
    input  logic [sbrg_pkg::SIDE_W-1:0]   i_side,
    input  logic                          i_ack,
    output sbrg_pkg::t_seq_stat           o_stat,
    output logic [sbrg_pkg::CELL_W-1:0]   o_value,
    output logic                          o_grid_we,
    output logic [AW-1:0]                 o_grid_waddr,
    output logic [sbrg_pkg::CELL_W-1:0]   o_grid_wdata,
    output logic [AW-1:0]                 o_grid_raddr,
    input  logic [sbrg_pkg::CELL_W-1:0]   i_grid_rdata,
    output logic                          o_scr_we,
    output logic [AW-1:0]                 o_scr_waddr,
    output logic [sbrg_pkg::CELL_W-1:0]   o_scr_wdata,
    output logic [AW-1:0]                 o_scr_raddr,
    input  logic [sbrg_pkg::CELL_W-1:0]   i_scr_rdata
);

    import sbrg_pkg::*;

    localparam int KW = ($clog2(MAX_SIDE + 1) > POS_W) ? $clog2(MAX_SIDE + 1) : POS_W;
    localparam int N0 = (MAX_SIDE < int'(GRID_SIZE_RESET)) ? MAX_SIDE : int'(GRID_SIZE_RESET);

    function automatic logic [AW-1:0] f_addr(input logic [KW-1:0] row,
                                             input logic [KW-1:0] col);
        return AW'(32'(row) * MAX_SIDE + 32'(col));
    endfunction

    t_state             r_state, n_state;
    logic [KW-1:0]      r_i, n_i, r_j, n_j;
    logic [KW-1:0]      r_lim, n_lim, r_r0, n_r0, r_c0, n_c0;
    logic               r_ccw, n_ccw;
    logic [CELL_W-1:0]  r_v, n_v, r_value, n_value;
    logic               r_status, n_status;
    logic               r_pw_grid, n_pw_grid, r_pw_scr, n_pw_scr;
    logic [AW-1:0]      r_pw_addr, n_pw_addr;

    logic [SIDE_W-1:0]  w_n;
    logic [POS_W:0]     w_row8, w_col8, w_rad8, w_n8;
    logic               w_rot_ok, w_rd_ok;
    logic [KW-1:0]      w_lim_m1;
    logic               w_last_j, w_last, w_init_in;
    logic [KW-1:0]      w_dst_row, w_dst_col, w_src_row, w_src_col;
    logic [AW-1:0]      w_a_ij, w_dst, w_src, w_rd_addr;

    // side in use saturates at the memory side
    assign w_n    = (int'(i_side) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : i_side;
    assign w_row8 = {1'b0, i_cmd.pos_row};
    assign w_col8 = {1'b0, i_cmd.pos_col};
    assign w_rad8 = (POS_W + 1)'(i_cmd.radius);
    assign w_n8   = (POS_W + 1)'(w_n);

    assign w_rot_ok = (w_row8 >= w_rad8 + 1'b1) && (w_row8 + w_rad8 <= w_n8) &&
                      (w_col8 >= w_rad8 + 1'b1) && (w_col8 + w_rad8 <= w_n8);
    assign w_rd_ok  = (w_row8 != '0) && (w_row8 <= w_n8) &&
                      (w_col8 != '0) && (w_col8 <= w_n8);

    assign w_lim_m1  = ((r_state == S_INIT) ? KW'(MAX_SIDE) : r_lim) - 1'b1;
    assign w_last_j  = (r_j == w_lim_m1);
    assign w_last    = w_last_j && (r_i == w_lim_m1);
    assign w_init_in = (r_i < KW'(N0)) && (r_j < KW'(N0));

    assign w_dst_row = r_r0 + r_i;
    assign w_dst_col = r_c0 + r_j;
    assign w_src_row = r_ccw ? (r_r0 + r_j) : (r_r0 + r_lim - 1'b1 - r_j);
    assign w_src_col = r_ccw ? (r_c0 + r_lim - 1'b1 - r_i) : (r_c0 + r_i);

    assign w_a_ij    = f_addr(r_i, r_j);
    assign w_dst     = f_addr(w_dst_row, w_dst_col);
    assign w_src     = f_addr(w_src_row, w_src_col);
    assign w_rd_addr = f_addr(KW'(i_cmd.pos_row) - 1'b1, KW'(i_cmd.pos_col) - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (w_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cmd.start) begin
                    case (i_cmd.op)
                        OP_NUMBER: n_state = (w_n != '0) ? S_NUMBER : S_DONE;
                        OP_ROTATE: n_state = w_rot_ok ? S_COPY : S_DONE;
                        OP_READ:   n_state = w_rd_ok ? S_RD_WAIT : S_DONE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_NUMBER: begin
                if (w_last) n_state = S_DONE;
            end
            S_COPY: begin
                if (w_last) n_state = S_COPY_END;
            end
            S_COPY_END: n_state = S_BACK;
            S_BACK: begin
                if (w_last) n_state = S_BACK_END;
            end
            S_BACK_END: n_state = S_DONE;
            S_RD_WAIT:  n_state = S_DONE;
            S_DONE: begin
                if (i_ack) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory ports and status
    always_comb begin
        o_grid_we    = r_pw_grid;
        o_grid_waddr = r_pw_addr;
        o_grid_wdata = i_scr_rdata;
        o_grid_raddr = w_src;
        o_scr_we     = r_pw_scr;
        o_scr_waddr  = r_pw_addr;
        o_scr_wdata  = i_grid_rdata;
        o_scr_raddr  = w_dst;
        o_stat.idle   = 1'b0;
        o_stat.done   = 1'b0;
        o_stat.status = r_status;
        case (r_state)
            S_INIT: begin
                o_grid_we    = 1'b1;
                o_grid_waddr = w_a_ij;
                o_grid_wdata = w_init_in ? r_v : '0;
            end
            S_NUMBER: begin
                o_grid_we    = 1'b1;
                o_grid_waddr = w_a_ij;
                o_grid_wdata = r_v;
            end
            S_IDLE: begin
                o_stat.idle  = 1'b1;
                o_grid_raddr = w_rd_addr;
            end
            S_DONE: o_stat.done = 1'b1;
            default: ;
        endcase
    end

    assign o_value = r_value;

    // counters and datapath registers
    always_comb begin
        n_i       = r_i;
        n_j       = r_j;
        n_lim     = r_lim;
        n_r0      = r_r0;
        n_c0      = r_c0;
        n_ccw     = r_ccw;
        n_v       = r_v;
        n_value   = r_value;
        n_status  = r_status;
        n_pw_grid = 1'b0;
        n_pw_scr  = 1'b0;
        n_pw_addr = r_pw_addr;
        if (r_state == S_INIT || r_state == S_NUMBER ||
            r_state == S_COPY || r_state == S_BACK) begin
            n_j = w_last_j ? '0 : r_j + 1'b1;
            n_i = w_last_j ? ((r_i == w_lim_m1) ? '0 : r_i + 1'b1) : r_i;
        end
        case (r_state)
            S_INIT: begin
                if (w_init_in) n_v = r_v + 1'b1;
            end
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_i      = '0;
                    n_j      = '0;
                    n_v      = CELL_W'(1);
                    n_value  = '0;
                    n_status = 1'b1;
                    n_ccw    = i_cmd.direction;
                    n_r0     = KW'(i_cmd.pos_row) - KW'(i_cmd.radius) - 1'b1;
                    n_c0     = KW'(i_cmd.pos_col) - KW'(i_cmd.radius) - 1'b1;
                    case (i_cmd.op)
                        OP_NUMBER: begin
                            n_status = 1'b0;
                            n_lim    = KW'(w_n);
                        end
                        OP_ROTATE: begin
                            n_status = !w_rot_ok;
                            n_lim    = KW'({i_cmd.radius, 1'b1});
                        end
                        OP_READ: n_status = !w_rd_ok;
                        default: n_status = 1'b1;
                    endcase
                end
            end
            S_NUMBER: n_v = r_v + 1'b1;
            S_COPY: begin
                n_pw_scr  = 1'b1;
                n_pw_addr = w_dst;
            end
            S_COPY_END: begin
                n_i = '0;
                n_j = '0;
            end
            S_BACK: begin
                n_pw_grid = 1'b1;
                n_pw_addr = w_dst;
            end
            S_RD_WAIT: n_value = i_grid_rdata;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_i       <= '0;
            r_j       <= '0;
            r_v       <= CELL_W'(1);
            r_pw_grid <= 1'b0;
            r_pw_scr  <= 1'b0;
            r_status  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_v       <= n_v;
            r_pw_grid <= n_pw_grid;
            r_pw_scr  <= n_pw_scr;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim     <= n_lim;
        r_r0      <= n_r0;
        r_c0      <= n_c0;
        r_ccw     <= n_ccw;
        r_value   <= n_value;
        r_pw_addr <= n_pw_addr;
    end

endmodule

// ===== design/square_block_rotate_grid_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_block_rotate_grid_core
// Grid of cell values with numbering, 90 degree block rotation and cell read.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+----------------------------
//  command  | in        | i_in_valid / o_in_ready     | op, pos_row, pos_col,
//           |           |                             | radius, direction
//  result   | out       | o_out_valid / i_out_ready   | cell_value, status
//  config   | in        | i_cfg_valid / o_cfg_ready   | grid_size
//
//  Timing: a command's length is set by the cells it walks, n*n for a numbering
//  and s*s twice for a rotation of side s (up to 63), at the single access per
//  cycle on each memory port.
//  Reset: a fill pass over all MAX_SIDE*MAX_SIDE cells numbers the grid memory;
//  no command beat is taken until it ends, config beats are always taken.
//  Stalls: a result waits in the output register while the next command runs;
//  the sequencer holds in its done state only if that register is still full.
//
module square_block_rotate_grid_core #(
    parameter int MAX_SIDE = sbrg_pkg::MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic [sbrg_pkg::POS_W-1:0]    i_pos_row,
    input  logic [sbrg_pkg::POS_W-1:0]    i_pos_col,
    input  logic [sbrg_pkg::RAD_W-1:0]    i_radius,
    input  logic                          i_direction,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sbrg_pkg::CELL_W-1:0]   o_cell_value,
    output logic                          o_status,
    // config channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sbrg_pkg::SIDE_W-1:0]   i_cfg_grid_size
);

    import sbrg_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SIDE_W-1:0]  r_grid_size;
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_cell_value;
    logic               r_status;

    t_cmd               w_cmd;
    t_seq_stat          w_stat;
    logic               w_ack;
    logic [CELL_W-1:0]  w_value;

    logic               w_grid_we, w_scr_we;
    logic [AW-1:0]      w_grid_waddr, w_grid_raddr, w_scr_waddr, w_scr_raddr;
    logic [CELL_W-1:0]  w_grid_wdata, w_grid_rdata, w_scr_wdata, w_scr_rdata;

    // take a command beat only while the sequencer is idle
    assign o_in_ready = w_stat.idle;
    assign o_cfg_ready = 1'b1;

    assign w_cmd.start     = i_in_valid && w_stat.idle;
    assign w_cmd.op        = t_op'(i_op);
    assign w_cmd.pos_row   = i_pos_row;
    assign w_cmd.pos_col   = i_pos_col;
    assign w_cmd.radius    = i_radius;
    assign w_cmd.direction = i_direction;

    // release the sequencer once the output register can take its result
    assign w_ack = w_stat.done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_grid_size <= i_cfg_grid_size;
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result payload until the beat is taken
    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_cell_value <= w_value;
            r_status     <= w_stat.status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_cell_value;
    assign o_status     = r_status;

    sbrg_seq #(
        .MAX_SIDE (MAX_SIDE),
        .AW       (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_side       (r_grid_size),
        .i_ack        (w_ack),
        .o_stat       (w_stat),
        .o_value      (w_value),
        .o_grid_we    (w_grid_we),
        .o_grid_waddr (w_grid_waddr),
        .o_grid_wdata (w_grid_wdata),
        .o_grid_raddr (w_grid_raddr),
        .i_grid_rdata (w_grid_rdata),
        .o_scr_we     (w_scr_we),
        .o_scr_waddr  (w_scr_waddr),
        .o_scr_wdata  (w_scr_wdata),
        .o_scr_raddr  (w_scr_raddr),
        .i_scr_rdata  (w_scr_rdata)
    );

    // grid cells
    sbrg_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_grid_we),
        .i_waddr (w_grid_waddr),
        .i_wdata (w_grid_wdata),
        .i_raddr (w_grid_raddr),
        .o_rdata (w_grid_rdata)
    );

    // scratch cells for the rotated block
    sbrg_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_scr_ram (
        .i_clk   (i_clk),
        .i_we    (w_scr_we),
        .i_waddr (w_scr_waddr),
        .i_wdata (w_scr_wdata),
        .i_raddr (w_scr_raddr),
        .o_rdata (w_scr_rdata)
    );

endmodule
